@@ design/ket_pkg.sv @@
// Shared types and constants for the keyed entry table.
// Used by the controller, the datapath, the top level and the testbench.
package ket_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int VALUE_BITS_DEFAULT = 64;

   localparam int KEY_W    = 16;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 5;
   localparam int PORT_VALUE_W = 64;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD    = 2'd0,
      ACT_GET    = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_UPDATE = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_DUP     = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE    = 2'd0,
      S_COMPARE = 2'd1,
      S_EXECUTE = 2'd2
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic compare;
      logic execute;
   } ctl_cmd_type;

endpackage

@@ design/ket_controller.sv @@
// Sequencer of the keyed entry table: load, compare, execute.
// Depends on ket_pkg for the state enum and the command struct.
module ket_controller
   import ket_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output ctl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_COMPARE;
         end
         S_COMPARE: begin
            state_in = S_EXECUTE;
         end
         S_EXECUTE: begin
            // The next request may enter while this one is written back.
            state_in = start ? S_COMPARE : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      busy        = 1'b0;
      cmd.load    = 1'b0;
      cmd.compare = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = start;
         end
         S_COMPARE: begin
            busy        = 1'b1;
            cmd.compare = 1'b1;
         end
         S_EXECUTE: begin
            cmd.load    = start;
            cmd.execute = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

@@ design/ket_datapath.sv @@
// Entry storage, parallel key compare, shift-down delete and response registers.
// Depends on ket_pkg; driven by the command struct from ket_controller.
module ket_datapath
   import ket_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  ctl_cmd_type             cmd,
   input  logic [ACTION_W-1:0]     req_action,
   input  logic [KEY_W-1:0]        req_key,
   input  logic [KEY_W-1:0]        req_new_key,
   input  logic [PORT_VALUE_W-1:0] req_entry_value,
   input  logic                    csr_write,
   input  logic [CAP_W-1:0]        csr_capacity,
   output logic                    rsp_valid,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [KEY_W-1:0]        rsp_found_key,
   output logic [PORT_VALUE_W-1:0] rsp_found_value
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [CAP_W-1:0]      capacity_ff;

   action_type            action_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [KEY_W-1:0]      new_key_ff;
   logic [VALUE_BITS-1:0] value_ff;

   logic [KEY_W-1:0]      tab_key_ff [DEPTH];
   logic [KEY_W-1:0]      tab_key_in [DEPTH];
   logic [VALUE_BITS-1:0] tab_val_ff [DEPTH];
   logic [VALUE_BITS-1:0] tab_val_in [DEPTH];
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;

   logic [DEPTH-1:0]      match_key;
   logic [DEPTH-1:0]      match_new;
   logic                  hit_ff, hit_in;
   logic                  dup_ff, dup_in;
   logic                  full_ff, full_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;

   logic                  rsp_valid_ff;
   status_type            status_ff, status_in;
   logic [KEY_W-1:0]      found_key_ff, found_key_in;
   logic [PORT_VALUE_W-1:0] found_value_ff, found_value_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_write) begin
         capacity_ff <= csr_capacity;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff  <= action_type'(req_action);
         key_ff     <= req_key;
         new_key_ff <= req_new_key;
         value_ff   <= req_entry_value[VALUE_BITS-1:0];
      end
   end

   // Compare the request keys against every live entry at once. Keys are
   // unique, so at most one entry matches the lookup key.
   always_comb begin
      pos_in = '0;
      for (int j = 0; j < DEPTH; j++) begin
         match_key[j] = (count_ff > CNT_W'(j)) && (tab_key_ff[j] == key_ff);
         match_new[j] = (count_ff > CNT_W'(j)) && (tab_key_ff[j] == new_key_ff);
         pos_in       = pos_in | (match_key[j] ? IDX_W'(j) : '0);
      end
      hit_in  = |match_key;
      dup_in  = |(match_new & ~match_key);
      full_in = (CMP_W'(count_ff) >= CMP_W'(capacity_ff)) ||
                (count_ff >= CNT_W'(DEPTH));
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         hit_ff  <= hit_in;
         dup_ff  <= dup_in;
         full_ff <= full_in;
         pos_ff  <= pos_in;
      end
   end

   always_comb begin
      tab_key_in     = tab_key_ff;
      tab_val_in     = tab_val_ff;
      count_in       = count_ff;
      status_in      = ST_OK;
      found_key_in   = '0;
      found_value_in = '0;
      case (action_ff)
         ACT_ADD: begin
            if (full_ff) begin
               status_in = ST_FULL;
            end else if (hit_ff) begin
               status_in = ST_DUP;
            end else begin
               tab_key_in[count_ff[IDX_W-1:0]] = key_ff;
               tab_val_in[count_ff[IDX_W-1:0]] = value_ff;
               count_in = count_ff + CNT_W'(1);
            end
         end
         ACT_GET: begin
            if (!hit_ff) begin
               status_in = ST_MISSING;
            end else begin
               found_key_in   = tab_key_ff[pos_ff];
               found_value_in = PORT_VALUE_W'(tab_val_ff[pos_ff]);
            end
         end
         ACT_DELETE: begin
            if (!hit_ff) begin
               status_in = ST_MISSING;
            end else begin
               // Every entry from the removed one upward takes its upper neighbor.
               for (int j = 0; j < DEPTH - 1; j++) begin
                  if (IDX_W'(j) >= pos_ff) begin
                     tab_key_in[j] = tab_key_ff[j + 1];
                     tab_val_in[j] = tab_val_ff[j + 1];
                  end
               end
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            if (!hit_ff) begin
               status_in = ST_MISSING;
            end else if (dup_ff) begin
               status_in = ST_DUP;
            end else begin
               tab_key_in[pos_ff] = new_key_ff;
               tab_val_in[pos_ff] = value_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         tab_key_ff <= tab_key_in;
         tab_val_ff <= tab_val_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.execute;
         if (cmd.execute) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff      <= status_in;
         found_key_ff   <= found_key_in;
         found_value_ff <= found_value_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_key   = found_key_ff;
   assign rsp_found_value = found_value_ff;

endmodule

@@ design/keyed_entry_table.sv @@
// Keyed entry table: a request is taken at an edge with start high and busy low.
// It passes the compare stage, where busy is high, then the write-back stage.
// The response strobe rsp_valid is registered after the write-back, for one cycle.
// A new request can be taken while the previous one is written back.
// Synchronous active-high reset empties the table and sets capacity to 16.
// Depends on ket_pkg, ket_controller and ket_datapath.
module keyed_entry_table
   import ket_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [ACTION_W-1:0]     req_action,
   input  logic [KEY_W-1:0]        req_key,
   input  logic [KEY_W-1:0]        req_new_key,
   input  logic [PORT_VALUE_W-1:0] req_entry_value,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CAP_W-1:0]        csr_capacity,
   output logic                    rsp_valid,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [KEY_W-1:0]        rsp_found_key,
   output logic [PORT_VALUE_W-1:0] rsp_found_value
);

   ctl_cmd_type cmd;

   assign csr_ready = !busy;

   ket_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   ket_datapath #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_action      (req_action),
      .req_key         (req_key),
      .req_new_key     (req_new_key),
      .req_entry_value (req_entry_value),
      .csr_write       (csr_valid && csr_ready),
      .csr_capacity    (csr_capacity),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found_key   (rsp_found_key),
      .rsp_found_value (rsp_found_value)
   );

endmodule

@@ design/ket_checker.sv @@
// Port-level timing checks for the keyed entry table, bound to the top level.
// Depends only on the top-level ports.
module ket_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // An accepted request holds the block busy for exactly one cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted request");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   // Every accepted request gets its response a fixed time later.
   a_response_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("response strobe missing after an accepted request");

   a_response_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid) && !$past(busy))
      else $error("response strobe without a request in flight");

endmodule

bind keyed_entry_table ket_checker u_ket_checker (.*);

@@ sim/tb_keyed_entry_table.sv @@
// Self-checking bench for keyed_entry_table: directed and random add, get, delete and update
// requests under several capacity settings, checked against a shadow copy of the table.
// Depends on ket_pkg and the keyed_entry_table RTL.
module tb_keyed_entry_table;
   import ket_pkg::*;

   localparam int DEPTH         = DEPTH_DEFAULT;
   localparam int VALUE_BITS    = VALUE_BITS_DEFAULT;
   localparam logic [PORT_VALUE_W-1:0] VALUE_MASK =
      {PORT_VALUE_W{1'b1}} >> (PORT_VALUE_W - VALUE_BITS);
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 6;
   localparam int POOL_SIZE     = 20;

   typedef struct packed {
      action_type              action;
      logic [KEY_W-1:0]        key;
      logic [KEY_W-1:0]        new_key;
      logic [PORT_VALUE_W-1:0] entry_value;
   } request_type;

   typedef struct packed {
      status_type              status;
      logic [KEY_W-1:0]        found_key;
      logic [PORT_VALUE_W-1:0] found_value;
   } response_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [ACTION_W-1:0]     req_action = '0;
   logic [KEY_W-1:0]        req_key = '0;
   logic [KEY_W-1:0]        req_new_key = '0;
   logic [PORT_VALUE_W-1:0] req_entry_value = '0;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CAP_W-1:0]        csr_capacity = CAP_RESET;
   logic                    rsp_valid;
   logic [STATUS_W-1:0]     rsp_status;
   logic [KEY_W-1:0]        rsp_found_key;
   logic [PORT_VALUE_W-1:0] rsp_found_value;

   keyed_entry_table dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_key         (req_key),
      .req_new_key     (req_new_key),
      .req_entry_value (req_entry_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_found_key   (rsp_found_key),
      .rsp_found_value (rsp_found_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the table contents and the capacity register.
   logic [KEY_W-1:0]        shadow_keys [DEPTH];
   logic [PORT_VALUE_W-1:0] shadow_values [DEPTH];
   int                      shadow_count = 0;
   logic [CAP_W-1:0]        shadow_capacity = CAP_RESET;

   request_type  request_backlog [$];
   response_type predicted_responses [$];
   int        items_queued = 0;
   int        results_seen = 0;
   int        mismatches = 0;
   int        cycle_count = 0;

   int        idle_left = 0;
   int        idle_odds = 6;
   bit        quiet_tail = 1'b0;
   bit        taken_last = 1'b0;

   logic [KEY_W-1:0] key_pool [POOL_SIZE];
   int               pool_span = POOL_SIZE;

   function automatic int find_slot(logic [KEY_W-1:0] k);
      int i;
      for (i = 0; i < shadow_count; i++)
         if (shadow_keys[i] == k)
            return i;
      return shadow_count;
   endfunction

   // Applies one request to the shadow table and returns the response it should produce.
   function automatic response_type table_apply(request_type r);
      response_type            res;
      int                      pos;
      int                      lim;
      logic [PORT_VALUE_W-1:0] v;
      res.status      = ST_OK;
      res.found_key   = '0;
      res.found_value = '0;
      v   = r.entry_value & VALUE_MASK;
      pos = find_slot(r.key);
      lim = (shadow_capacity < DEPTH) ? int'(shadow_capacity) : DEPTH;
      case (r.action)
         ACT_ADD: begin
            // The full check wins over the duplicate check.
            if (shadow_count >= lim)
               res.status = ST_FULL;
            else if (pos < shadow_count)
               res.status = ST_DUP;
            else if (shadow_count < DEPTH) begin
               shadow_keys[shadow_count]   = r.key;
               shadow_values[shadow_count] = v;
               shadow_count++;
            end
         end
         ACT_GET: begin
            if (pos >= shadow_count)
               res.status = ST_MISSING;
            else begin
               res.found_key   = shadow_keys[pos];
               res.found_value = shadow_values[pos] & VALUE_MASK;
            end
         end
         ACT_DELETE: begin
            if (pos >= shadow_count)
               res.status = ST_MISSING;
            else begin
               for (int j = pos; j + 1 < shadow_count; j++) begin
                  shadow_keys[j]   = shadow_keys[j + 1];
                  shadow_values[j] = shadow_values[j + 1];
               end
               shadow_count--;
            end
         end
         default: begin
            if (pos >= shadow_count)
               res.status = ST_MISSING;
            else begin
               // Renaming an entry to its own key is allowed.
               for (int j = 0; j < shadow_count; j++)
                  if (j != pos && shadow_keys[j] == r.new_key)
                     res.status = ST_DUP;
               if (res.status == ST_OK) begin
                  shadow_keys[pos]   = r.new_key;
                  shadow_values[pos] = v;
               end
            end
         end
      endcase
      return res;
   endfunction

   function automatic request_type make_req(action_type a, logic [KEY_W-1:0] k,
                                            logic [KEY_W-1:0] nk,
                                            logic [PORT_VALUE_W-1:0] v);
      request_type r;
      r.action      = a;
      r.key         = k;
      r.new_key     = nk;
      r.entry_value = v;
      return r;
   endfunction

   function automatic void queue_request(request_type r);
      request_backlog.push_back(r);
      items_queued++;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(0, 99) < 85)
         return key_pool[$urandom_range(0, pool_span - 1)];
      return KEY_W'($urandom_range(0, 65535));
   endfunction

   function automatic request_type draw_request(int w_add, int w_get, int w_del, int w_upd);
      request_type r;
      int          pick;
      pick = $urandom_range(0, w_add + w_get + w_del + w_upd - 1);
      if (pick < w_add)
         r.action = ACT_ADD;
      else if (pick < w_add + w_get)
         r.action = ACT_GET;
      else if (pick < w_add + w_get + w_del)
         r.action = ACT_DELETE;
      else
         r.action = ACT_UPDATE;
      r.key     = pick_key();
      r.new_key = pick_key();
      case ($urandom_range(0, 9))
         0: r.entry_value = '0;
         1: r.entry_value = '1;
         default: r.entry_value = {$urandom, $urandom};
      endcase
      return r;
   endfunction

   // Capacity is only changed once every outstanding request has been answered.
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      wait (results_seen == items_queued);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid    <= 1'b1;
      csr_capacity <= cap;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Request driver: holds each request until it is taken, with random idle bursts.
   always @(negedge clock) begin
      request_type next_req;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !taken_last) begin
         // The block has not taken the current request yet.
      end else if (idle_left > 0) begin
         start <= 1'b0;
         idle_left--;
      end else if (request_backlog.size() > 0) begin
         next_req = request_backlog.pop_front();
         start           <= 1'b1;
         req_action      <= next_req.action;
         req_key         <= next_req.key;
         req_new_key     <= next_req.new_key;
         req_entry_value <= next_req.entry_value;
         if (!quiet_tail && idle_odds > 0 && $urandom_range(1, idle_odds) == 1)
            idle_left = $urandom_range(1, 18);
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: checks responses, tracks capacity writes and predicts each taken request.
   always @(posedge clock) begin
      response_type want;
      request_type  taken;
      taken_last = 1'b0;
      if (!reset) begin
         if (rsp_valid) begin
            results_seen++;
            if (predicted_responses.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none, %s %0d key %h value %h",
                        $time, "actual status", rsp_status, rsp_found_key,
                        rsp_found_value);
            end else begin
               want = predicted_responses.pop_front();
               if (rsp_status !== want.status) begin
                  mismatches++;
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_found_key !== want.found_key) begin
                  mismatches++;
                  $display("%0t: found_key mismatch, expected %h, actual %h",
                           $time, want.found_key, rsp_found_key);
               end
               if (rsp_found_value !== want.found_value) begin
                  mismatches++;
                  $display("%0t: found_value mismatch, expected %h, actual %h",
                           $time, want.found_value, rsp_found_value);
               end
            end
         end
         if (csr_valid && csr_ready)
            shadow_capacity = csr_capacity;
         if (start && !busy) begin
            taken_last          = 1'b1;
            taken.action        = action_type'(req_action);
            taken.key           = req_key;
            taken.new_key       = req_new_key;
            taken.entry_value   = req_entry_value;
            predicted_responses.push_back(table_apply(taken));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [CAP_W-1:0] phase_caps [8];
      int               phase_len;
      phase_caps = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd8, 5'd0, 5'd12, 5'd16};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, starting from the empty table at the reset capacity.
      queue_request(make_req(ACT_GET,    16'h1234, 16'h0005, 64'h0));
      queue_request(make_req(ACT_DELETE, 16'h1234, 16'hFFFF, 64'h0));
      queue_request(make_req(ACT_UPDATE, 16'h1234, 16'h0005, 64'h1));
      queue_request(make_req(ACT_ADD,    16'h0000, 16'hFFFF, 64'h0));
      queue_request(make_req(ACT_ADD,    16'hFFFF, 16'h0000, '1));
      queue_request(make_req(ACT_ADD,    16'h1234, 16'h0000, 64'hA5A5_A5A5_A5A5_A5A5));
      queue_request(make_req(ACT_ADD,    16'hFFFF, 16'h0000, 64'h1));
      queue_request(make_req(ACT_GET,    16'hFFFF, 16'h0000, 64'h0));
      queue_request(make_req(ACT_GET,    16'h0000, 16'hFFFF, '1));
      queue_request(make_req(ACT_UPDATE, 16'h1234, 16'h1234, 64'h5A5A_5A5A_5A5A_5A5A));
      queue_request(make_req(ACT_UPDATE, 16'h1234, 16'h0000, 64'h2));
      queue_request(make_req(ACT_UPDATE, 16'h1234, 16'h4321, 64'h0123_4567_89AB_CDEF));
      queue_request(make_req(ACT_GET,    16'h4321, 16'h0000, 64'h0));
      queue_request(make_req(ACT_DELETE, 16'h0000, 16'h0000, 64'h0));
      queue_request(make_req(ACT_GET,    16'h4321, 16'h0000, 64'h0));
      queue_request(make_req(ACT_ADD,    16'h0BAD, 16'h0000, 64'hFEDC_BA98_7654_3210));
      // Capacity lowered below the entry count: old entries stay usable.
      write_capacity(5'd2);
      queue_request(make_req(ACT_ADD,    16'h7777, 16'h0000, 64'h3));
      queue_request(make_req(ACT_ADD,    16'hFFFF, 16'h0000, 64'h4));
      queue_request(make_req(ACT_GET,    16'h0BAD, 16'h0000, 64'h0));
      write_capacity(5'd0);
      queue_request(make_req(ACT_DELETE, 16'hFFFF, 16'h0000, 64'h0));
      queue_request(make_req(ACT_ADD,    16'h0001, 16'h0000, 64'h5));
      write_capacity(5'd1);
      queue_request(make_req(ACT_DELETE, 16'h4321, 16'h0000, 64'h0));
      queue_request(make_req(ACT_ADD,    16'h0002, 16'h0000, 64'h6));
      queue_request(make_req(ACT_GET,    16'h4321, 16'h0000, 64'h0));

      // Random phases alternate between filling and draining the table.
      for (int phase = 0; phase < 8; phase++) begin
         write_capacity(phase_caps[phase]);
         for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom_range(0, 65535));
         if ($urandom_range(0, 1) == 1) begin
            key_pool[0] = '0;
            key_pool[1] = '1;
         end
         pool_span  = $urandom_range(6, POOL_SIZE);
         idle_odds  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
         quiet_tail = (phase == 7);
         phase_len  = (phase_caps[phase] == 0) ? 30 : 80;
         for (int i = 0; i < phase_len; i++) begin
            if (phase % 2 == 0)
               queue_request(draw_request(5, 3, 1, 2));
            else
               queue_request(draw_request(2, 3, 4, 3));
         end
      end

      wait (results_seen == items_queued);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (predicted_responses.size() != 0) begin
         mismatches++;
         $display("%0t: %0d responses expected but never seen",
                  $time, predicted_responses.size());
      end
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ files.f @@
design/ket_pkg.sv
design/ket_controller.sv
design/ket_datapath.sv
design/keyed_entry_table.sv
design/ket_checker.sv
sim/tb_keyed_entry_table.sv
